### hw/rtl/mrrs_pkg.sv
// Package: shared types, constants and CRC helper for the Modbus RTU register server.
`timescale 1ns / 1ps
`default_nettype none
package mrrs_pkg;

  localparam int unsigned REG_COUNT_DEFAULT = 3;
  localparam int unsigned FRAME_LEN         = 8;
  localparam int unsigned FB_IDX_W          = $clog2(FRAME_LEN);
  localparam int unsigned CNT_W             = $clog2(FRAME_LEN + 1);
  localparam int unsigned BYTE_W            = 8;
  localparam int unsigned WORD_W            = 16;
  localparam int unsigned EVENT_W           = 3;
  localparam int unsigned QUEUE_DEPTH       = 2;
  localparam int unsigned QPTR_W            = $clog2(QUEUE_DEPTH);
  localparam int unsigned QCNT_W            = $clog2(QUEUE_DEPTH + 1);

  localparam logic [WORD_W-1:0] CRC_INIT = 16'hFFFF;
  localparam logic [WORD_W-1:0] CRC_POLY = 16'hA001;

  localparam logic [BYTE_W-1:0] SERVER_ID_RESET = 8'h01;

  localparam logic [BYTE_W-1:0] FN_READ_HOLDING  = 8'h03;
  localparam logic [BYTE_W-1:0] FN_WRITE_SINGLE  = 8'h06;
  localparam logic [BYTE_W-1:0] FN_EXCEPTION_BIT = 8'h80;

  localparam logic [BYTE_W-1:0] EXC_ILLEGAL_FUNCTION = 8'h01;
  localparam logic [BYTE_W-1:0] EXC_ILLEGAL_ADDRESS  = 8'h02;

  localparam logic [WORD_W-1:0] CMD_OPERATIONAL    = 16'h0001;
  localparam logic [WORD_W-1:0] CMD_PREOPERATIONAL = 16'h0080;
  localparam logic [WORD_W-1:0] CMD_RESET          = 16'h0081;
  localparam logic [WORD_W-1:0] CMD_STOP           = 16'h0002;

  typedef enum logic [EVENT_W-1:0] {
    EV_NONE           = 3'd0,
    EV_OPERATIONAL    = 3'd1,
    EV_PREOPERATIONAL = 3'd2,
    EV_RESET          = 3'd3,
    EV_STOP           = 3'd4
  } cmd_event_t;

  typedef enum logic [1:0] {
    REQ_WRITE,
    REQ_READ,
    REQ_EXCEPT
  } req_kind_t;

  typedef struct packed {
    req_kind_t         kind;
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] fn;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] value;
    logic [BYTE_W-1:0] exc_code;
  } req_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_BODY,
    BK_CRC_HI,
    BK_CRC_LO
  } back_state_t;

  function automatic logic [WORD_W-1:0] crc16_byte(input logic [WORD_W-1:0] crc_in,
                                                   input logic [BYTE_W-1:0] data);
    logic [WORD_W-1:0] crc;
    crc = crc_in ^ {8'h00, data};
    for (int k = 0; k < 8; k++) begin
      if (crc[0]) begin
        crc = (crc >> 1) ^ CRC_POLY;
      end else begin
        crc = crc >> 1;
      end
    end
    return crc;
  endfunction

endpackage
`default_nettype wire

### hw/rtl/mrrs_front.sv
// Front end: collects request bytes, runs the CRC, checks the frame and classifies it.
`timescale 1ns / 1ps
`default_nettype none
module mrrs_front #(
  parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEFAULT
) (
  input  wire logic                       clk,
  input  wire logic                       rst,
  input  wire logic [mrrs_pkg::BYTE_W-1:0] server_id,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic [mrrs_pkg::BYTE_W-1:0] rx_byte,
  input  wire logic                       frame_start,
  input  wire logic                       q_full,
  output logic                            q_push,
  output mrrs_pkg::req_t                  q_data
);
  import mrrs_pkg::*;

  logic [BYTE_W-1:0] frame_bytes [FRAME_LEN-1];
  logic [CNT_W-1:0]  byte_count;
  logic [WORD_W-1:0] running_crc;

  logic              accept;
  logic [CNT_W-1:0]  cnt_eff;
  logic [WORD_W-1:0] crc_eff;
  logic              in_frame;
  logic              last_in;
  logic              frame_ok;
  logic [WORD_W-1:0] addr;
  logic [WORD_W-1:0] value;
  logic [BYTE_W-1:0] fn;
  logic [WORD_W:0]   read_end;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    cnt_eff  = frame_start ? '0 : byte_count;
    crc_eff  = frame_start ? CRC_INIT : running_crc;
    in_frame = cnt_eff < CNT_W'(FRAME_LEN);
    last_in  = cnt_eff == CNT_W'(FRAME_LEN - 1);
    frame_ok = ({frame_bytes[6], rx_byte} == crc_eff) && (frame_bytes[0] == server_id);
    fn       = frame_bytes[1];
    addr     = {frame_bytes[2], frame_bytes[3]};
    value    = {frame_bytes[4], frame_bytes[5]};
    read_end = {1'b0, addr} + {1'b0, value};
  end

  always_comb begin
    q_data.id       = frame_bytes[0];
    q_data.fn       = fn;
    q_data.addr     = addr;
    q_data.value    = value;
    q_data.kind     = REQ_EXCEPT;
    q_data.exc_code = EXC_ILLEGAL_FUNCTION;
    case (fn)
      FN_WRITE_SINGLE: begin
        if (addr >= WORD_W'(REG_COUNT)) begin
          q_data.exc_code = EXC_ILLEGAL_ADDRESS;
        end else begin
          q_data.kind = REQ_WRITE;
        end
      end
      FN_READ_HOLDING: begin
        if (read_end > (WORD_W + 1)'(REG_COUNT)) begin
          q_data.exc_code = EXC_ILLEGAL_ADDRESS;
        end else begin
          q_data.kind = REQ_READ;
        end
      end
      default: begin
        q_data.kind     = REQ_EXCEPT;
        q_data.exc_code = EXC_ILLEGAL_FUNCTION;
      end
    endcase
  end

  assign q_push = accept && in_frame && last_in && frame_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count  <= '0;
      running_crc <= CRC_INIT;
    end else if (accept) begin
      byte_count  <= cnt_eff;
      running_crc <= crc_eff;
      if (in_frame) begin
        byte_count <= cnt_eff + CNT_W'(1);
        if (cnt_eff < CNT_W'(FRAME_LEN - 2)) begin
          running_crc <= crc16_byte(crc_eff, rx_byte);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept && in_frame && !last_in) begin
      frame_bytes[cnt_eff[FB_IDX_W-1:0]] <= rx_byte;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mrrs_queue.sv
// Short request queue between the front end and the reply engine.
`timescale 1ns / 1ps
`default_nettype none
module mrrs_queue (
  input  wire logic           clk,
  input  wire logic           rst,
  input  wire logic           push,
  input  wire mrrs_pkg::req_t push_data,
  output logic                full,
  input  wire logic           pop,
  output mrrs_pkg::req_t      pop_data,
  output logic                not_empty
);
  import mrrs_pkg::*;

  req_t              entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;

  logic do_push;
  logic do_pop;

  assign full      = count == QCNT_W'(QUEUE_DEPTH);
  assign not_empty = count != '0;
  assign pop_data  = entries[rd_ptr];
  assign do_push   = push && !full;
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
        count <= count - QCNT_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/mrrs_back.sv
// Reply engine: register file, command detection and reply byte stream with CRC.
`timescale 1ns / 1ps
`default_nettype none
module mrrs_back #(
  parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        q_not_empty,
  input  wire mrrs_pkg::req_t              q_data,
  output logic                             q_pop,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [mrrs_pkg::BYTE_W-1:0]      tx_byte,
  output logic                             last_byte,
  output logic [mrrs_pkg::EVENT_W-1:0]     command_event
);
  import mrrs_pkg::*;

  localparam int unsigned RIDX_W  = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int unsigned MAX_LEN = 3 + 2 * REG_COUNT;
  localparam int unsigned LEN_W   = $clog2(MAX_LEN + 1);
  localparam int unsigned QTY_W   = $clog2(REG_COUNT + 1);

  back_state_t       state;
  back_state_t       state_next;

  logic [WORD_W-1:0] register_file [REG_COUNT];
  logic [WORD_W-1:0] last_acted_command;
  req_t              req;
  cmd_event_t        event_code;
  logic [LEN_W-1:0]  idx;
  logic [LEN_W-1:0]  body_last;
  logic [RIDX_W-1:0] rd_addr;
  logic              rd_hi;
  logic [WORD_W-1:0] crc;

  logic              out_free;
  logic              load;
  logic [BYTE_W-1:0] load_byte;
  logic              load_last;
  cmd_event_t        load_event;
  logic [BYTE_W-1:0] body_byte;
  logic [WORD_W-1:0] reg_word;
  logic [WORD_W-1:0] reg0_new;
  cmd_event_t        ev_new;
  logic [LEN_W-1:0]  len_new;

  assign out_free = !out_valid || !out_stall;
  assign reg_word = register_file[rd_addr];

  always_comb begin
    state_next = state;
    case (state)
      BK_IDLE:   if (q_not_empty) state_next = BK_BODY;
      BK_BODY:   if (out_free && idx == body_last) state_next = BK_CRC_HI;
      BK_CRC_HI: if (out_free) state_next = BK_CRC_LO;
      BK_CRC_LO: if (out_free) state_next = BK_IDLE;
      default:   state_next = BK_IDLE;
    endcase
  end

  always_comb begin
    body_byte = req.id;
    case (req.kind)
      REQ_WRITE: begin
        case (idx)
          LEN_W'(0): body_byte = req.id;
          LEN_W'(1): body_byte = req.fn;
          LEN_W'(2): body_byte = req.addr[15:8];
          LEN_W'(3): body_byte = req.addr[7:0];
          LEN_W'(4): body_byte = req.value[15:8];
          default:   body_byte = req.value[7:0];
        endcase
      end
      REQ_READ: begin
        case (idx)
          LEN_W'(0): body_byte = req.id;
          LEN_W'(1): body_byte = req.fn;
          LEN_W'(2): body_byte = {req.value[6:0], 1'b0};
          default:   body_byte = rd_hi ? reg_word[15:8] : reg_word[7:0];
        endcase
      end
      default: begin
        case (idx)
          LEN_W'(0): body_byte = req.id;
          LEN_W'(1): body_byte = req.fn | FN_EXCEPTION_BIT;
          default:   body_byte = req.exc_code;
        endcase
      end
    endcase
  end

  always_comb begin
    q_pop      = 1'b0;
    load       = 1'b0;
    load_byte  = body_byte;
    load_last  = 1'b0;
    load_event = EV_NONE;
    case (state)
      BK_IDLE: q_pop = q_not_empty;
      BK_BODY: load = out_free;
      BK_CRC_HI: begin
        load      = out_free;
        load_byte = crc[15:8];
      end
      BK_CRC_LO: begin
        load       = out_free;
        load_byte  = crc[7:0];
        load_last  = 1'b1;
        load_event = event_code;
      end
      default: q_pop = 1'b0;
    endcase
  end

  always_comb begin
    reg0_new = (q_data.addr == '0) ? q_data.value : register_file[0];
    ev_new   = EV_NONE;
    if (reg0_new != last_acted_command) begin
      if (reg0_new == CMD_OPERATIONAL) ev_new = EV_OPERATIONAL;
      else if (reg0_new == CMD_PREOPERATIONAL) ev_new = EV_PREOPERATIONAL;
      else if (reg0_new == CMD_RESET) ev_new = EV_RESET;
      else if (reg0_new == CMD_STOP) ev_new = EV_STOP;
    end
    case (q_data.kind)
      REQ_WRITE: len_new = LEN_W'(6);
      REQ_READ:  len_new = LEN_W'(3) + LEN_W'({q_data.value[QTY_W-1:0], 1'b0});
      default:   len_new = LEN_W'(3);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state              <= BK_IDLE;
      out_valid          <= 1'b0;
      last_acted_command <= '0;
      for (int i = 0; i < REG_COUNT; i++) begin
        register_file[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      if (q_pop && q_data.kind == REQ_WRITE) begin
        register_file[q_data.addr[RIDX_W-1:0]] <= q_data.value;
        if (ev_new != EV_NONE) begin
          last_acted_command <= reg0_new;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      req        <= q_data;
      idx        <= '0;
      body_last  <= len_new - LEN_W'(1);
      rd_addr    <= q_data.addr[RIDX_W-1:0];
      rd_hi      <= 1'b1;
      crc        <= CRC_INIT;
      event_code <= (q_data.kind == REQ_WRITE) ? ev_new : EV_NONE;
    end else if (state == BK_BODY && out_free) begin
      idx <= idx + LEN_W'(1);
      crc <= crc16_byte(crc, body_byte);
      if (idx >= LEN_W'(3)) begin
        rd_hi <= !rd_hi;
        if (!rd_hi) begin
          rd_addr <= rd_addr + RIDX_W'(1);
        end
      end
    end
    if (load) begin
      tx_byte       <= load_byte;
      last_byte     <= load_last;
      command_event <= load_event;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/modbus_rtu_register_server.sv
// Top level of the Modbus RTU register server (functions 3 and 6).
// Flow: the eighth request byte pushes the request into the queue; the reply engine pops it when idle,
// then registers and streams the reply one byte per cycle (5 to 3 + 2*REG_COUNT + 2 bytes) unless stalled.
// Throughput: one request byte per cycle while the 2-entry request queue has room.
// Reset: synchronous; clears byte count, CRC, register file and command history, id to 1.
`timescale 1ns / 1ps
`default_nettype none
module modbus_rtu_register_server #(
  parameter int unsigned REG_COUNT = mrrs_pkg::REG_COUNT_DEFAULT
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_valid,
  output logic                              cfg_ready,
  input  wire logic [mrrs_pkg::BYTE_W-1:0]  cfg_data,
  input  wire logic                         in_valid,
  output logic                              in_stall,
  input  wire logic [mrrs_pkg::BYTE_W-1:0]  rx_byte,
  input  wire logic                         frame_start,
  output logic                              out_valid,
  input  wire logic                         out_stall,
  output logic [mrrs_pkg::BYTE_W-1:0]       tx_byte,
  output logic                              last_byte,
  output logic [mrrs_pkg::EVENT_W-1:0]      command_event
);
  import mrrs_pkg::*;

  logic [BYTE_W-1:0] server_id;
  logic              q_full;
  logic              q_push;
  req_t              q_push_data;
  logic              q_pop;
  req_t              q_pop_data;
  logic              q_not_empty;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_id <= SERVER_ID_RESET;
    end else if (cfg_valid && cfg_ready) begin
      server_id <= cfg_data;
    end
  end

  mrrs_front #(.REG_COUNT(REG_COUNT)) u_front (
    .clk         (clk),
    .rst         (rst),
    .server_id   (server_id),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rx_byte     (rx_byte),
    .frame_start (frame_start),
    .q_full      (q_full),
    .q_push      (q_push),
    .q_data      (q_push_data)
  );

  mrrs_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_push_data),
    .full      (q_full),
    .pop       (q_pop),
    .pop_data  (q_pop_data),
    .not_empty (q_not_empty)
  );

  mrrs_back #(.REG_COUNT(REG_COUNT)) u_back (
    .clk           (clk),
    .rst           (rst),
    .q_not_empty   (q_not_empty),
    .q_data        (q_pop_data),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_byte       (tx_byte),
    .last_byte     (last_byte),
    .command_event (command_event)
  );

endmodule
`default_nettype wire

### test/tb_modbus_rtu_register_server.sv
// Testbench for modbus_rtu_register_server: directed and random frames against a predictor.
`timescale 1ns / 1ps
module tb_modbus_rtu_register_server;
  import mrrs_pkg::*;

  localparam int unsigned REG_N = REG_COUNT_DEFAULT;
  localparam int PHASE_BYTES = 20;
  localparam int SETTLE_CYCLES = 24;
  localparam int HOLD_CYCLES = 400;
  localparam int HOLD_FRAMES = 6;
  localparam int UNTYPED = 99;

  // function codes this server does not implement
  localparam logic [BYTE_W-1:0] FN_NONE            = 8'h00;
  localparam logic [BYTE_W-1:0] FN_ALL_ONES        = 8'hFF;
  localparam logic [BYTE_W-1:0] FN_WRITE_MULTIPLE  = 8'h10;

  typedef struct packed {
    logic [BYTE_W-1:0] data;
    logic              last;
    cmd_event_t        ev;
  } tx_beat_t;

  typedef struct packed {
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] fn;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] val;
    logic              crc_ok;
    logic              start;
    int                nbytes;
    int                exp_len;
    int                exp_b2;
    int                exp_ev;
  } probe_t;

  logic                clk;
  logic                rst;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [BYTE_W-1:0]   cfg_data;
  logic                in_valid;
  logic                in_stall;
  logic [BYTE_W-1:0]   rx_byte;
  logic                frame_start;
  logic                out_valid;
  logic                out_stall;
  logic [BYTE_W-1:0]   tx_byte;
  logic                last_byte;
  logic [EVENT_W-1:0]  command_event;

  // predictor state
  logic [BYTE_W-1:0]   my_id = SERVER_ID_RESET;
  logic [BYTE_W-1:0]   frame_buf [FRAME_LEN];
  int unsigned         fill = 0;
  logic [WORD_W-1:0]   regs [REG_N] = '{default: '0};
  logic [WORD_W-1:0]   acted_cmd = '0;
  logic [WORD_W-1:0]   crc_acc = CRC_INIT;

  tx_beat_t            tx_pending [$];
  int                  mismatch_count = 0;
  int                  bytes_taken = 0;
  int                  send_gap_pct = 0;
  int                  rx_stall_pct = 0;
  int                  hold_left = 0;

  modbus_rtu_register_server #(.REG_COUNT(REG_N)) DUT (
    .clk           (clk),
    .rst           (rst),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_data      (cfg_data),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .frame_start   (frame_start),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .tx_byte       (tx_byte),
    .last_byte     (last_byte),
    .command_event (command_event)
  );

  function automatic logic [WORD_W-1:0] crc_step(input logic [WORD_W-1:0] acc,
                                                 input logic [BYTE_W-1:0] b);
    logic fb;
    for (int i = 0; i < 8; i++) begin
      fb = acc[0] ^ b[i];
      acc = acc >> 1;
      if (fb) begin
        acc = acc ^ CRC_POLY;
      end
    end
    return acc;
  endfunction

  function automatic void append_with_crc(ref tx_beat_t burst[$], input logic [BYTE_W-1:0] body[$],
                                          input cmd_event_t ev);
    logic [WORD_W-1:0] crc;
    crc = CRC_INIT;
    foreach (body[i]) begin
      crc = crc_step(crc, body[i]);
      burst.push_back('{data: body[i], last: 1'b0, ev: EV_NONE});
    end
    burst.push_back('{data: crc[15:8], last: 1'b0, ev: EV_NONE});
    burst.push_back('{data: crc[7:0], last: 1'b1, ev: ev});
  endfunction

  function automatic void exception_reply(ref tx_beat_t burst[$], input logic [BYTE_W-1:0] fn,
                                          input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0] body [$];
    body = '{my_id, fn | FN_EXCEPTION_BIT, code};
    append_with_crc(burst, body, EV_NONE);
  endfunction

  // Folds one accepted request byte into the model; fills burst with the reply it causes.
  task automatic absorb_rx_byte(input logic [BYTE_W-1:0] b, input logic s, output bit taken,
                                ref tx_beat_t burst[$]);
    logic [BYTE_W-1:0] fn;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] qty;
    logic [WORD_W-1:0] r;
    logic [BYTE_W-1:0] body [$];
    cmd_event_t        ev;
    taken = 1'b0;
    if (s) begin
      fill = 0;
      crc_acc = CRC_INIT;
    end
    if (fill < FRAME_LEN) begin
      taken = 1'b1;
      frame_buf[fill] = b;
      if (fill < FRAME_LEN - 2) begin
        crc_acc = crc_step(crc_acc, b);
      end
      fill++;
      if (fill == FRAME_LEN && {frame_buf[6], frame_buf[7]} == crc_acc &&
          frame_buf[0] == my_id) begin
        fn = frame_buf[1];
        addr = {frame_buf[2], frame_buf[3]};
        qty = {frame_buf[4], frame_buf[5]};
        if (fn == FN_WRITE_SINGLE) begin
          if (addr >= REG_N) begin
            exception_reply(burst, fn, EXC_ILLEGAL_ADDRESS);
          end else begin
            regs[addr] = qty;
            ev = EV_NONE;
            if (regs[0] != acted_cmd) begin
              case (regs[0])
                CMD_OPERATIONAL:    ev = EV_OPERATIONAL;
                CMD_PREOPERATIONAL: ev = EV_PREOPERATIONAL;
                CMD_RESET:          ev = EV_RESET;
                CMD_STOP:           ev = EV_STOP;
                default:            ev = EV_NONE;
              endcase
              if (ev != EV_NONE) begin
                acted_cmd = regs[0];
              end
            end
            for (int i = 0; i < 6; i++) begin
              body.push_back(frame_buf[i]);
            end
            append_with_crc(burst, body, ev);
          end
        end else if (fn == FN_READ_HOLDING) begin
          if (int'(addr) + int'(qty) > REG_N) begin
            exception_reply(burst, fn, EXC_ILLEGAL_ADDRESS);
          end else begin
            body = '{my_id, fn, {qty[6:0], 1'b0}};
            for (int i = 0; i < int'(qty); i++) begin
              r = regs[int'(addr) + i];
              body.push_back(r[15:8]);
              body.push_back(r[7:0]);
            end
            append_with_crc(burst, body, EV_NONE);
          end
        end else begin
          exception_reply(burst, fn, EXC_ILLEGAL_FUNCTION);
        end
      end
    end
  endtask

  // One request byte transfer; valid stays high for the next call unless a gap is drawn.
  task automatic push_byte(input logic [BYTE_W-1:0] b, input logic s, ref tx_beat_t got[$]);
    tx_beat_t burst [$];
    bit       taken;
    while ($urandom_range(99) < send_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    rx_byte <= b;
    frame_start <= s;
    @(posedge clk);
    while (in_stall !== 1'b0) @(posedge clk);
    absorb_rx_byte(b, s, taken, burst);
    if (taken) begin
      bytes_taken++;
    end
    foreach (burst[i]) begin
      tx_pending.push_back(burst[i]);
      got.push_back(burst[i]);
    end
  endtask

  // nbytes < 8 cuts the frame short; nbytes > 8 appends random trailing bytes.
  task automatic send_frame(input logic [BYTE_W-1:0] id, input logic [BYTE_W-1:0] fn,
                            input logic [WORD_W-1:0] addr, input logic [WORD_W-1:0] val,
                            input bit crc_ok, input bit start, input int nbytes,
                            ref tx_beat_t got[$]);
    logic [BYTE_W-1:0] raw [FRAME_LEN];
    logic [WORD_W-1:0] crc;
    raw = '{id, fn, addr[15:8], addr[7:0], val[15:8], val[7:0], 8'h00, 8'h00};
    crc = CRC_INIT;
    for (int i = 0; i < 6; i++) begin
      crc = crc_step(crc, raw[i]);
    end
    if (!crc_ok) begin
      crc = crc ^ 16'($urandom_range(1, 16'hFFFF));
    end
    raw[6] = crc[15:8];
    raw[7] = crc[7:0];
    for (int i = 0; i < nbytes; i++) begin
      push_byte((i < FRAME_LEN) ? raw[i] : 8'($urandom_range(255)), (i == 0) ? start : 1'b0, got);
    end
  endtask

  task automatic random_frame();
    logic [BYTE_W-1:0] id;
    logic [BYTE_W-1:0] fn;
    logic [WORD_W-1:0] addr;
    logic [WORD_W-1:0] val;
    int                pick;
    int                nb;
    int                r;
    tx_beat_t          got [$];
    pick = $urandom_range(99);
    if (pick >= 90) begin
      nb = $urandom_range(1, 6);
      repeat (nb) push_byte(8'($urandom_range(255)), 1'($urandom_range(1)), got);
      return;
    end
    id = ($urandom_range(99) < 88) ? my_id : 8'($urandom_range(255));
    r = $urandom_range(99);
    fn = (r < 46) ? FN_WRITE_SINGLE : (r < 92) ? FN_READ_HOLDING : 8'($urandom_range(255));
    addr = ($urandom_range(99) < 85) ? 16'($urandom_range(REG_N)) : 16'($urandom());
    if (fn == FN_WRITE_SINGLE) begin
      if ($urandom_range(1)) begin
        addr = '0;
      end
      r = $urandom_range(99);
      if (r < 45) begin
        case ($urandom_range(3))
          0: val = CMD_OPERATIONAL;
          1: val = CMD_PREOPERATIONAL;
          2: val = CMD_RESET;
          default: val = CMD_STOP;
        endcase
      end else begin
        val = (r < 65) ? 16'($urandom_range(3)) : 16'($urandom());
      end
    end else begin
      val = ($urandom_range(99) < 85) ? 16'($urandom_range(REG_N)) : 16'($urandom());
    end
    nb = (pick >= 80) ? $urandom_range(1, 7) : (pick >= 72) ? $urandom_range(9, 11) : FRAME_LEN;
    send_frame(id, fn, addr, val, $urandom_range(99) < 94, $urandom_range(99) < 92, nb, got);
  endtask

  task automatic wait_replies();
    in_valid <= 1'b0;
    while (tx_pending.size() != 0) @(posedge clk);
  endtask

  task automatic settle();
    wait_replies();
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_server_id(input logic [BYTE_W-1:0] v);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    @(posedge clk);
    while (cfg_ready !== 1'b1) @(posedge clk);
    cfg_valid <= 1'b0;
    my_id = v;
  endtask

  task automatic run_phase(input logic [BYTE_W-1:0] id, input int gap, input int stall);
    settle();
    write_server_id(id);
    send_gap_pct = gap;
    rx_stall_pct = stall;
    bytes_taken = 0;
    while (bytes_taken < PHASE_BYTES) random_frame();
  endtask

  probe_t probes [28] = '{
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b1, 1'b0, 8, 11, 6, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0000, 1'b1, 1'b1, 8, 5, 0, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_OPERATIONAL, 1'b1, 1'b1, 8, 8, UNTYPED, EV_OPERATIONAL},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_OPERATIONAL, 1'b1, 1'b1, 8, 8, UNTYPED, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_PREOPERATIONAL, 1'b1, 1'b1, 8, 8, UNTYPED,
      EV_PREOPERATIONAL},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_RESET, 1'b1, 1'b1, 8, 8, UNTYPED, EV_RESET},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_STOP, 1'b1, 1'b1, 8, 8, UNTYPED, EV_STOP},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, 16'h1234, 1'b1, 1'b1, 8, 8, UNTYPED, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_STOP, 1'b1, 1'b1, 8, 8, UNTYPED, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0002, 16'hFFFF, 1'b1, 1'b1, 8, 8, UNTYPED, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0001, 16'h0000, 1'b1, 1'b1, 8, 8, UNTYPED, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'h0003, 16'h5555, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_ADDRESS, EV_NONE},
    '{8'h01, FN_WRITE_SINGLE, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_ADDRESS, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0002, 16'h0002, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_ADDRESS, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'hFFFF, 16'hFFFF, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_ADDRESS, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0001, 16'h0002, 1'b1, 1'b1, 8, 9, 4, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0003, 16'h0000, 1'b1, 1'b1, 8, 5, 0, EV_NONE},
    '{8'h01, FN_NONE, 16'h0000, 16'h0001, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_FUNCTION, EV_NONE},
    '{8'h01, FN_ALL_ONES, 16'hFFFF, 16'h0000, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_FUNCTION, EV_NONE},
    '{8'h01, FN_WRITE_MULTIPLE, 16'h0000, 16'h0002, 1'b1, 1'b1, 8, 5, EXC_ILLEGAL_FUNCTION,
      EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b0, 1'b1, 8, 0, UNTYPED, UNTYPED},
    '{8'h00, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b1, 1'b1, 8, 0, UNTYPED, UNTYPED},
    '{8'hFF, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b1, 1'b1, 8, 0, UNTYPED, UNTYPED},
    '{8'h02, FN_WRITE_SINGLE, 16'h0000, CMD_OPERATIONAL, 1'b1, 1'b1, 8, 0, UNTYPED, UNTYPED},
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b1, 1'b1, 13, 11, 6, EV_NONE},
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0001, 1'b1, 1'b1, 5, 0, UNTYPED, UNTYPED},
    '{8'h01, FN_WRITE_SINGLE, 16'h0000, CMD_OPERATIONAL, 1'b1, 1'b1, 8, 8, UNTYPED, EV_OPERATIONAL},
    '{8'h01, FN_READ_HOLDING, 16'h0000, 16'h0003, 1'b1, 1'b1, 8, 11, 6, EV_NONE}
  };

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  initial begin
    #2_000_000;
    $display("TEST FAILED");
    $finish;
  end

  // receiver: random stalls, or a long hold-off when requested
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < rx_stall_pct);
      end
    end
  end

  initial begin
    tx_beat_t want;
    forever begin
      @(posedge clk);
      if (!rst && out_valid === 1'b1 && !out_stall) begin
        if (tx_pending.size() == 0) begin
          $error("unexpected reply byte: tx_byte %02h last_byte %b", tx_byte, last_byte);
          mismatch_count++;
        end else begin
          want = tx_pending.pop_front();
          if (tx_byte !== want.data) begin
            $error("tx_byte: expected %02h, got %02h", want.data, tx_byte);
            mismatch_count++;
          end
          if (last_byte !== want.last) begin
            $error("last_byte: expected %b, got %b", want.last, last_byte);
            mismatch_count++;
          end
          if (command_event !== want.ev) begin
            $error("command_event: expected %0d, got %0d", want.ev, command_event);
            mismatch_count++;
          end
        end
      end
    end
  end

  initial begin
    tx_beat_t got [$];
    rst = 1'b1;
    cfg_valid = 1'b0;
    cfg_data = '0;
    in_valid = 1'b0;
    rx_byte = '0;
    frame_start = 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    foreach (probes[k]) begin
      got.delete();
      send_frame(probes[k].id, probes[k].fn, probes[k].addr, probes[k].val, probes[k].crc_ok,
                 probes[k].start, probes[k].nbytes, got);
      if (probes[k].exp_len != UNTYPED && got.size() != probes[k].exp_len) begin
        $error("reply length, case %0d: expected %0d, got %0d", k, probes[k].exp_len, got.size());
        mismatch_count++;
      end
      if (probes[k].exp_b2 != UNTYPED && got.size() > 2 && got[2].data != probes[k].exp_b2) begin
        $error("reply byte 2, case %0d: expected %02h, got %02h", k, probes[k].exp_b2,
               got[2].data);
        mismatch_count++;
      end
      if (probes[k].exp_ev != UNTYPED && got.size() > 0 && got[$].ev != probes[k].exp_ev) begin
        $error("command_event, case %0d: expected %0d, got %0d", k, probes[k].exp_ev,
               got[$].ev);
        mismatch_count++;
      end
    end

    run_phase(8'd247, 0, 0);
    run_phase(8'd1, 51, 0);
    run_phase(8'h88, 0, 51);
    run_phase(8'($urandom_range(1, 247)), 32, 32);

    // long receiver hold-off fills the block; then a pause until all replies are out
    settle();
    write_server_id(8'($urandom_range(1, 247)));
    send_gap_pct = 0;
    rx_stall_pct = 0;
    hold_left = HOLD_CYCLES;
    repeat (HOLD_FRAMES) begin
      send_frame(my_id, FN_READ_HOLDING, 16'h0000, 16'(REG_N), 1'b1, 1'b1, FRAME_LEN, got);
    end
    wait_replies();
    bytes_taken = 0;
    while (bytes_taken < PHASE_BYTES / 2) random_frame();

    settle();
    if (tx_pending.size() != 0) begin
      $error("%0d reply bytes never arrived", tx_pending.size());
      mismatch_count++;
    end
    if (mismatch_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
